[rtl/first_fit_block_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
// Expects clk and rst_n in the scope of the including module.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define FFBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ffba_pkg.sv]
// Package for the first-fit block allocator: widths, codes, reset values,
// divider request/response structs. No dependencies.
`default_nettype none

package ffba_pkg;

  // field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned BSIZE_W = 17;
  localparam int unsigned REQ_W   = 27;
  localparam int unsigned TAG_W   = 11;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 2;

  // counters that must hold a pool size plus one
  localparam int unsigned SC_W    = TAG_W + 1;
  localparam int unsigned TAG_MAX = (1 << TAG_W) - 1;

  // divider
  localparam int unsigned DIV_W     = ADDR_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // defaults
  localparam int unsigned DEF_MAX_BLOCKS = 1024;
  localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE = BSIZE_W'(64);
  localparam logic [TAG_W-1:0]   RST_TOTAL      = TAG_W'(1024);

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BSIZE = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TOTAL = 2'd2;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_FEW     = 3'd1,
    ST_NORUN   = 3'd2,
    ST_BADADDR = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  // divider handshake
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [BSIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic             rem_nz;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/ffba_ifs.sv]
// Valid/ready channel interfaces for allocator requests and results.
// Depends on ffba_pkg for field widths.
`default_nettype none

interface ffba_req_if import ffba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [REQ_W-1:0]   request_bytes;
  logic [ADDR_W-1:0]  release_address;

  modport source (output valid, operation, request_bytes, release_address,
                  input ready);
  modport sink   (input valid, operation, request_bytes, release_address,
                  output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [ADDR_W-1:0]  granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink   (input valid, status, granted_address, output ready);
endinterface

`default_nettype wire

[rtl/ffba_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/ffba_div.sv]
// Restoring divider, one quotient bit per cycle; reports quotient and
// whether the remainder is nonzero. Depends on ffba_pkg.
`default_nettype none

module ffba_div import ffba_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [BSIZE_W-1:0]   rem_r, rem_nxt;
  logic [BSIZE_W-1:0]   dvs_r, dvs_nxt;
  logic [BSIZE_W:0]     trial;
  logic                 ge;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    ge       = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? BSIZE_W'(trial - {1'b0, dvs_r}) : trial[BSIZE_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
  assign rsp.rem_nz   = |rem_r;

endmodule

`default_nettype wire

[rtl/first_fit_block_allocator.sv]
// First-fit contiguous block allocator, top level.
// Depends on ffba_pkg, ffba_ifs, ffba_ram, ffba_div, assertion macros.
//
// Usage:
//  in_req  : request words {operation, request_bytes, release_address}.
//            Allocate rounds request_bytes up to whole blocks and claims the
//            lowest-start free run; free clears the run tagged at an address.
//  out_rsp : one result word {status, granted_address} per request.
//  cfg_*   : write-only registers (base address, block size, total blocks),
//            written while the block is idle. Writing total blocks frees
//            the whole pool.
// One request is worked at a time. Apart from the cases screened out below,
// each request first goes through the bit-serial divider (bytes to blocks,
// or address to index). An allocate then scans the tag memory one entry
// per cycle and writes one tag per cycle for the run it takes. A free
// walks as many entries as the run length, one per cycle. Zero-byte and
// below-base requests skip the divider and go straight to the result.
// After reset, and after each total-blocks write, a clearing pass zeroes
// one tag entry per cycle over the pool; no request is taken meanwhile.
// A stalled result sits in the output register while the next request is
// already accepted and worked.
`default_nettype none

`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  ffba_req_if.sink               in_req,
  ffba_rsp_if.source             out_rsp
);

  localparam int unsigned IDX_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned POOL_CAP = (MAX_BLOCKS < TAG_MAX) ? MAX_BLOCKS : TAG_MAX;
  localparam int unsigned PROD_W   = BSIZE_W + SC_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_AL_RD,
    S_AL_SCAN,
    S_AL_FILL,
    S_MUL,
    S_ADD,
    S_FR_RD,
    S_FR_RUN,
    S_DONE
  } state_t;

  // pool size actually in use
  function automatic logic [TAG_W-1:0] clamp_pool(input logic [TAG_W-1:0] t);
    clamp_pool = (t > TAG_W'(POOL_CAP)) ? TAG_W'(POOL_CAP) : t;
  endfunction

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [BSIZE_W-1:0]  bsize_r, bsize_nxt;
  logic [TAG_W-1:0]    total_r, total_nxt;
  logic [TAG_W-1:0]    free_r, free_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                op_r, op_nxt;
  logic [SC_W-1:0]     ptr_r, ptr_nxt;
  logic [SC_W-1:0]     fill_r, fill_nxt;
  logic [SC_W-1:0]     start_r, start_nxt;
  logic [TAG_W-1:0]    run_r, run_nxt;
  logic [TAG_W-1:0]    want_r, want_nxt;
  logic [TAG_W-1:0]    cnt_r, cnt_nxt;
  logic [TAG_W-1:0]    k_r, k_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  status_t             res_st_r, res_st_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  status_t             out_st_r, out_st_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;

  logic [TAG_W-1:0]    pool_n;
  logic [SC_W-1:0]     pool_ext;
  logic [BSIZE_W-1:0]  bs_eff;
  logic                in_fire;
  logic                out_fire;
  logic [DIV_W-1:0]    want_full;
  logic [TAG_W-1:0]    run_inc;
  logic [TAG_W-1:0]    cnt_cur;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                ram_we;
  logic [SC_W-1:0]     ram_waddr;
  logic [TAG_W-1:0]    ram_wdata;
  logic [SC_W-1:0]     ram_raddr;
  logic [TAG_W-1:0]    ram_rdata;

  // block tag store: run length per block, zero when free
  ffba_ram #(
    .WIDTH (TAG_W),
    .DEPTH (MAX_BLOCKS)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(ram_waddr)),
    .wdata (ram_wdata),
    .raddr (IDX_W'(ram_raddr)),
    .rdata (ram_rdata)
  );

  // bytes-to-blocks and address-to-index division
  ffba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign pool_n    = clamp_pool(total_r);
  assign pool_ext  = SC_W'(pool_n);
  assign bs_eff    = (bsize_r == '0) ? BSIZE_W'(1) : bsize_r;
  assign in_fire   = in_req.valid & in_req.ready;
  assign out_fire  = out_rsp.valid & out_rsp.ready;
  assign want_full = div_rsp.quotient + DIV_W'(div_rsp.rem_nz);
  assign run_inc   = run_r + 1'b1;
  assign cnt_cur   = (k_r == '0) ? ram_rdata : cnt_r;

  assign in_req.ready            = (state_r == S_IDLE);
  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_st_r;
  assign out_rsp.granted_address = out_addr_r;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    bsize_nxt     = bsize_r;
    total_nxt     = total_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    start_nxt     = start_r;
    run_nxt       = run_r;
    want_nxt      = want_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    res_st_nxt    = res_st_r;
    res_addr_nxt  = res_addr_r;
    out_st_nxt    = out_st_r;
    out_addr_nxt  = out_addr_r;

    div_req.start    = 1'b0;
    div_req.dividend = (in_req.operation == OP_ALLOC) ?
                       DIV_W'(in_req.request_bytes) :
                       (in_req.release_address - base_r);
    div_req.divisor  = bs_eff;

    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = '0;
    ram_raddr = ptr_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // zero the pool after reset or a resize
      S_CLEAR: begin
        if (ptr_r >= pool_ext) begin
          state_nxt = S_IDLE;
        end else begin
          ram_we  = 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      // accept a word; screen trivial cases, else start the divider
      S_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_req.operation;
          res_addr_nxt = '0;
          if (in_req.operation == OP_ALLOC && in_req.request_bytes == '0) begin
            res_st_nxt = ST_ZERO;
            state_nxt  = S_DONE;
          end else if (in_req.operation == OP_FREE &&
                       in_req.release_address < base_r) begin
            res_st_nxt = ST_BADADDR;
            state_nxt  = S_DONE;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          ptr_nxt = '0;
          run_nxt = '0;
          k_nxt   = '0;
          if (op_r == OP_ALLOC) begin
            if (want_full > DIV_W'(free_r)) begin
              res_st_nxt = ST_FEW;
              state_nxt  = S_DONE;
            end else begin
              want_nxt  = TAG_W'(want_full);
              state_nxt = S_AL_RD;
            end
          end else begin
            if (div_rsp.quotient >= DIV_W'(pool_n)) begin
              res_st_nxt = ST_BADADDR;
              state_nxt  = S_DONE;
            end else begin
              ptr_nxt   = SC_W'(div_rsp.quotient);
              state_nxt = S_FR_RD;
            end
          end
        end
      end

      S_AL_RD: begin
        state_nxt = S_AL_SCAN;
      end

      // rdata is the tag at ptr_r; the next entry is read meanwhile
      S_AL_SCAN: begin
        ram_raddr = ptr_r + 1'b1;
        if (ptr_r >= pool_ext) begin
          res_st_nxt = ST_NORUN;
          state_nxt  = S_DONE;
        end else if (ram_rdata != '0) begin
          run_nxt = '0;
          ptr_nxt = ptr_r + 1'b1;
        end else if (run_inc == want_r) begin
          start_nxt = ptr_r + 1'b1 - SC_W'(want_r);
          fill_nxt  = ptr_r + 1'b1 - SC_W'(want_r);
          free_nxt  = free_r - want_r;
          state_nxt = S_AL_FILL;
        end else begin
          run_nxt = run_inc;
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      // tag the claimed run, ptr_r holds its last block
      S_AL_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_r;
        ram_wdata = want_r;
        fill_nxt  = fill_r + 1'b1;
        if (fill_r == ptr_r) begin
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        prod_nxt  = PROD_W'(bs_eff) * PROD_W'(start_r);
        state_nxt = S_ADD;
      end

      S_ADD: begin
        res_addr_nxt = base_r + ADDR_W'(prod_r);
        res_st_nxt   = ST_OK;
        state_nxt    = S_DONE;
      end

      S_FR_RD: begin
        state_nxt = S_FR_RUN;
      end

      // first word read gives the run length; clear nonzero tags in turn
      S_FR_RUN: begin
        ram_raddr = ptr_r + 1'b1;
        if (k_r < cnt_cur && ptr_r < pool_ext) begin
          if (ram_rdata != '0) begin
            ram_we   = 1'b1;
            free_nxt = free_r + 1'b1;
          end
          cnt_nxt = cnt_cur;
          k_nxt   = k_r + 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          res_st_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end

      // hand over to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_addr_nxt  = res_addr_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_BASE: begin
          base_nxt = cfg_data;
        end
        CFG_BSIZE: begin
          bsize_nxt = cfg_data[BSIZE_W-1:0];
        end
        CFG_TOTAL: begin
          total_nxt = cfg_data[TAG_W-1:0];
          free_nxt  = clamp_pool(cfg_data[TAG_W-1:0]);
          ptr_nxt   = '0;
          state_nxt = S_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      base_r      <= '0;
      bsize_r     <= RST_BLOCK_SIZE;
      total_r     <= RST_TOTAL;
      free_r      <= clamp_pool(RST_TOTAL);
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      bsize_r     <= bsize_nxt;
      total_r     <= total_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
    end
    op_r       <= op_nxt;
    fill_r     <= fill_nxt;
    start_r    <= start_nxt;
    run_r      <= run_nxt;
    want_r     <= want_nxt;
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    prod_r     <= prod_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
  end

  // free count never exceeds the pool
  `FFBA_ASSERT_ALWAYS(a_free_le_pool, free_r <= pool_n, "free count above pool size")
  // the first-fit scan only reads the tag store
  `FFBA_ASSERT_IMP(a_scan_no_write, state_r == S_AL_SCAN, !ram_we, "tag write during scan")
  // an accepted word always starts work
  `FFBA_ASSERT_NEXT(a_accept_busy, in_fire, state_r != S_IDLE, "idle right after accept")
  // tag writes stay inside the pool
  `FFBA_ASSERT_IMP(a_write_in_pool, ram_we && !cfg_we, ram_waddr < pool_ext,
                   "tag write beyond pool")

endmodule

`default_nettype wire
